### rtl/brdz_pkg.sv
package brdz_pkg;

  localparam int unsigned CodeWidth   = 16;
  localparam int unsigned ExtraWidth  = 12;
  localparam int unsigned DzWidth     = 15;
  localparam int unsigned ExtraShift  = 4;
  localparam logic [CodeWidth-1:0] MidscaleCode = 16'd32768;
  localparam logic [CodeWidth-1:0] CodeMax      = 16'hFFFF;

  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned OutTdataWidth = 48;

  localparam logic [2:0] RegStepSize   = 3'd0;
  localparam logic [2:0] RegDeadZone   = 3'd1;
  localparam logic [2:0] RegStepPeriod = 3'd2;
  localparam logic [2:0] RegMainMask   = 3'd3;
  localparam logic [2:0] RegExtraMask  = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_APPROACH,
    PH_JUMP,
    PH_FINAL
  } phase_e;

  typedef struct packed {
    logic [CodeWidth-1:0] step_size;
    logic [DzWidth-1:0]   dead_zone;
    logic [CodeWidth-1:0] step_period;
    logic [CodeWidth-1:0] main_mask;
    logic [CodeWidth-1:0] extra_mask;
  } cfg_t;

  typedef struct packed {
    logic [CodeWidth-1:0]  full_code;
    logic [CodeWidth-1:0]  main_code;
    logic [ExtraWidth-1:0] extra_code;
    logic                  extra_write;
    logic                  last_step;
  } result_t;

endpackage

### rtl/brdz_core.sv
module brdz_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  brdz_pkg::cfg_t                 cfg_i,
  input  logic                           item_valid_i,
  input  logic                           item_kind_i,
  input  logic [brdz_pkg::CodeWidth-1:0] item_target_i,
  output logic                           res_valid_o,
  output brdz_pkg::result_t              res_o
);
  import brdz_pkg::*;

  logic [CodeWidth-1:0] cur_q, cur_d;
  logic [CodeWidth-1:0] goal_q, goal_d;
  phase_e               phase_q, phase_d;
  logic                 up_q, up_d;
  logic [CodeWidth-1:0] tick_q, tick_d;

  function automatic phase_e settle_phase(phase_e ph, logic up, logic [CodeWidth-1:0] cur,
                                          logic [CodeWidth-1:0] goal,
                                          logic [CodeWidth-1:0] lo,
                                          logic [CodeWidth-1:0] hi);
    phase_e               p;
    logic [CodeWidth-1:0] near;
    p    = ph;
    near = up ? lo : hi;
    if (p == PH_APPROACH && !(up ? (cur < near) : (cur > near))) begin
      p = PH_JUMP;
    end
    if (p == PH_FINAL && !(up ? (cur < goal) : (cur > goal))) begin
      p = PH_IDLE;
    end
    return p;
  endfunction

  function automatic logic [CodeWidth-1:0] move_toward(logic up, logic [CodeWidth-1:0] c,
                                                       logic [CodeWidth-1:0] limit,
                                                       logic [CodeWidth-1:0] st);
    logic [CodeWidth:0]   sum;
    logic [CodeWidth-1:0] n;
    sum = {1'b0, c} + {1'b0, st};
    if (up) begin
      n = (sum > {1'b0, limit}) ? limit : sum[CodeWidth-1:0];
    end else begin
      n = (c > st) ? (c - st) : '0;
      if (n < limit) begin
        n = limit;
      end
    end
    return n;
  endfunction

  logic [CodeWidth:0]   hi_sum;
  logic [CodeWidth:0]   tick_next;
  logic [CodeWidth-1:0] low_edge, high_edge, step_eff, period_eff;
  logic [CodeWidth-1:0] goal_sel, code_new;
  logic                 start, up0, up_sel, emit;
  phase_e               ph0, ph1, emit_ph, ph2, ph3;

  always_comb begin
    hi_sum     = {1'b0, MidscaleCode} + {2'b0, cfg_i.dead_zone};
    low_edge   = ({1'b0, cfg_i.dead_zone} >= MidscaleCode) ? '0
                 : MidscaleCode - {1'b0, cfg_i.dead_zone};
    high_edge  = hi_sum[CodeWidth] ? CodeMax : hi_sum[CodeWidth-1:0];
    step_eff   = (cfg_i.step_size == '0) ? CodeWidth'(1) : cfg_i.step_size;
    period_eff = (cfg_i.step_period == '0) ? CodeWidth'(1) : cfg_i.step_period;

    start = !item_kind_i;
    if (item_target_i > MidscaleCode && cur_q < MidscaleCode) begin
      up0 = 1'b1;
      ph0 = PH_APPROACH;
    end else if (item_target_i < MidscaleCode && cur_q > MidscaleCode) begin
      up0 = 1'b0;
      ph0 = PH_APPROACH;
    end else begin
      up0 = item_target_i > cur_q;
      ph0 = PH_FINAL;
    end
    ph1 = settle_phase(ph0, up0, cur_q, item_target_i, low_edge, high_edge);

    tick_next = {1'b0, tick_q} + 1'b1;
    up_sel    = start ? up0 : up_q;
    goal_sel  = start ? item_target_i : goal_q;
    emit_ph   = start ? ph1 : phase_q;
    emit      = start ? (ph1 != PH_IDLE)
                : (phase_q != PH_IDLE && tick_next >= {1'b0, period_eff});

    case (emit_ph)
      PH_APPROACH: code_new = move_toward(up_sel, cur_q, up_sel ? low_edge : high_edge,
                                          step_eff);
      PH_JUMP:     code_new = up_sel ? high_edge : low_edge;
      default:     code_new = move_toward(up_sel, cur_q, goal_sel, step_eff);
    endcase
    ph2 = (emit_ph == PH_JUMP) ? PH_FINAL : emit_ph;
    ph3 = settle_phase(ph2, up_sel, code_new, goal_sel, low_edge, high_edge);
  end

  always_comb begin
    cur_d   = cur_q;
    goal_d  = goal_q;
    phase_d = phase_q;
    up_d    = up_q;
    tick_d  = tick_q;
    if (item_valid_i) begin
      goal_d = goal_sel;
      up_d   = up_sel;
      if (emit) begin
        cur_d   = code_new;
        phase_d = ph3;
        tick_d  = '0;
      end else if (start) begin
        phase_d = ph1;
        tick_d  = '0;
      end else if (phase_q != PH_IDLE) begin
        tick_d = tick_next[CodeWidth-1:0];
      end
    end
  end

  always_comb begin
    logic [CodeWidth-1:0] shifted;
    shifted                = (code_new & cfg_i.extra_mask) >> ExtraShift;
    res_valid_o            = item_valid_i && emit;
    res_o.full_code        = code_new;
    res_o.main_code        = code_new & cfg_i.main_mask;
    res_o.extra_code       = shifted[ExtraWidth-1:0];
    res_o.extra_write      = (cur_q & cfg_i.extra_mask) != (code_new & cfg_i.extra_mask);
    res_o.last_step        = (ph3 == PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= MidscaleCode;
      goal_q  <= '0;
      phase_q <= PH_IDLE;
      up_q    <= 1'b0;
      tick_q  <= '0;
    end else begin
      cur_q   <= cur_d;
      goal_q  <= goal_d;
      phase_q <= phase_d;
      up_q    <= up_d;
      tick_q  <= tick_d;
    end
  end

endmodule

### rtl/bias_ramp_with_dead_zone_top.sv
// Bias ramp generator with a midscale dead zone. Start and tick items enter on the slave
// stream; each is taken into an input register and handled once the result register is
// free or being taken, where the step add and clamp and the dead-zone edge compares update
// the kept code and load the result register. One item is accepted in every cycle unless
// the input register is full while a result still waits to be taken; a result appears on
// the master stream in the cycle after its item is handled. The input register and the
// result register let the next item enter while a result still waits to be taken. Items
// that cause no step give no result. The user must write configuration over the APB port
// only while the block is idle; the block itself does not enforce this. There is no clearing pass after reset.
module bias_ramp_with_dead_zone_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [brdz_pkg::AddrWidth-1:0]     paddr,
  input  logic [brdz_pkg::DataWidth-1:0]     pwdata,
  output logic [brdz_pkg::DataWidth-1:0]     prdata,
  output logic                               pready,
  // Input items
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [brdz_pkg::CodeWidth-1:0]     s_axis_tdata,   // [15:0] target_code
  input  logic [0:0]                         s_axis_tuser,   // [0] kind
  // Result items
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [brdz_pkg::OutTdataWidth-1:0] m_axis_tdata,   // [15:0] full_code,
                                                             // [31:16] main_code,
                                                             // [43:32] extra_code,
                                                             // [47:44] zero
  output logic [0:0]                         m_axis_tuser,   // [0] extra_write
  output logic                               m_axis_tlast    // last_step
);
  import brdz_pkg::*;

  cfg_t    cfg_q;
  logic    cfg_we;
  logic [2:0] cfg_idx;

  logic                 in_valid_q;
  logic                 in_kind_q;
  logic [CodeWidth-1:0] in_target_q;
  logic                 advance;
  logic                 s_accept;

  logic    core_res_valid;
  result_t core_res;
  logic    out_valid_q;
  result_t out_q;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[AddrWidth-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size   <= CodeWidth'(1);
      cfg_q.dead_zone   <= '0;
      cfg_q.step_period <= '0;
      cfg_q.main_mask   <= CodeMax;
      cfg_q.extra_mask  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        RegStepSize:   cfg_q.step_size   <= pwdata[CodeWidth-1:0];
        RegDeadZone:   cfg_q.dead_zone   <= pwdata[DzWidth-1:0];
        RegStepPeriod: cfg_q.step_period <= pwdata[CodeWidth-1:0];
        RegMainMask:   cfg_q.main_mask   <= pwdata[CodeWidth-1:0];
        RegExtraMask:  cfg_q.extra_mask  <= pwdata[CodeWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegStepSize:   prdata = DataWidth'(cfg_q.step_size);
      RegDeadZone:   prdata = DataWidth'(cfg_q.dead_zone);
      RegStepPeriod: prdata = DataWidth'(cfg_q.step_period);
      RegMainMask:   prdata = DataWidth'(cfg_q.main_mask);
      RegExtraMask:  prdata = DataWidth'(cfg_q.extra_mask);
      default:       prdata = '0;
    endcase
  end

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_kind_q   <= s_axis_tuser[0];
      in_target_q <= s_axis_tdata;
    end
  end

  brdz_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .item_valid_i  (advance),
    .item_kind_i   (in_kind_q),
    .item_target_i (in_target_q),
    .res_valid_o   (core_res_valid),
    .res_o         (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= core_res_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && core_res_valid) begin
      out_q <= core_res;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = {4'b0, out_q.extra_code, out_q.main_code, out_q.full_code};
  assign m_axis_tuser[0] = out_q.extra_write;
  assign m_axis_tlast    = out_q.last_step;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a waiting result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_res_valid |-> advance)
    else $error("step produced outside a handled item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_kind_q) && $stable(in_target_q)))
    else $error("held input item changed or lost");

endmodule
